[hw/rtl/cgi_pkg.sv]
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared types and constants of the colour glow interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cgi_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned NUM_CH   = 3;
    // |peak - base| times k
    localparam int unsigned PROD_W   = 24;
    // q = W/4 fits in 14 bits
    localparam int unsigned Q_W      = 14;
    // quotient of the blend never exceeds about twice the channel span
    localparam int unsigned QUO_W    = 10;
    localparam int unsigned IDX_W    = 2;

    // modulo stages, k stage, product stage, blend divide stages, output stage
    localparam int unsigned LATENCY  = TIME_W + 1 + 1 + PROD_W + 1;

    localparam logic [WIN_W-1:0]   WINDOW_RST = 16'd2000;
    localparam logic [COLOR_W-1:0] BASE_RST   = 24'h000000;
    localparam logic [COLOR_W-1:0] PEAK_RST   = 24'hFFFFFF;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_BASE   = 2'd1,
        REG_PEAK   = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

[hw/rtl/cgi_mod.sv]
// ----------------------------------------------------------------------------
// cgi_mod
// Pipelined restoring remainder: time stamp modulo the window, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cgi_mod
    import cgi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [TIME_W-1:0] i_time,
    input  wire logic [WIN_W-1:0]  i_window,
    output logic                   o_valid,
    output logic [WIN_W-1:0]       o_rem
);

    logic [TIME_W-1:0] r_vld;
    logic [WIN_W-1:0]  r_rem [TIME_W];
    logic [TIME_W-1:0] r_num [TIME_W];

    genvar gi;
    generate
        for (gi = 0; gi < TIME_W; gi++) begin : g_stage
            logic              in_vld;
            logic [WIN_W-1:0]  in_rem;
            logic [TIME_W-1:0] in_num;
            logic [WIN_W:0]    trial;
            logic [WIN_W-1:0]  n_rem;

            if (gi == 0) begin : g_first
                assign in_vld = i_valid;
                assign in_rem = '0;
                assign in_num = i_time;
            end else begin : g_next
                assign in_vld = r_vld[gi-1];
                assign in_rem = r_rem[gi-1];
                assign in_num = r_num[gi-1];
            end

            // shift in the next dividend bit, subtract when it fits
            always_comb begin
                trial = {in_rem, in_num[TIME_W-1]};
                if (trial >= {1'b0, i_window}) begin
                    n_rem = WIN_W'(trial - {1'b0, i_window});
                end else begin
                    n_rem = trial[WIN_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gi] <= 1'b0;
                end else begin
                    r_vld[gi] <= in_vld;
                end
                r_rem[gi] <= n_rem;
                r_num[gi] <= {in_num[TIME_W-2:0], 1'b0};
            end
        end
    endgenerate

    assign o_valid = r_vld[TIME_W-1];
    assign o_rem   = r_rem[TIME_W-1];

endmodule

`default_nettype wire

[hw/rtl/color_glow_interpolator.sv]
// ----------------------------------------------------------------------------
// color_glow_interpolator
// Maps a millisecond time stamp to a triangular crossfade between a base
// colour and a peak colour over a configurable window.
// ----------------------------------------------------------------------------
// Channel   | Signals                                   | Transfer
// ----------|-------------------------------------------|---------------------
// command   | start, busy, i_time_ms                    | start & !busy
// result    | o_valid, o_color_out                      | o_valid, one cycle
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data| valid & ready
//
// One time stamp enters every cycle; busy is never raised.
// Each result passes through 32 modulo stages, one stage for the ramp
// position, one for the products, 24 blend-divide stages and the output
// register.
// Reset clears all valid bits; configuration returns to its reset values.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module color_glow_interpolator
    import cgi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [TIME_W-1:0]  i_time_ms,
    output logic                    o_valid,
    output logic [COLOR_W-1:0]      o_color_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [COLOR_W-1:0] i_cfg_data
);

    logic [WIN_W-1:0]   r_window;
    logic [COLOR_W-1:0] r_base;
    logic [COLOR_W-1:0] r_peak;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_base   <= BASE_RST;
            r_peak   <= PEAK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                REG_BASE:   r_base   <= i_cfg_data;
                REG_PEAK:   r_peak   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // modulo pipeline
    logic             mod_vld;
    logic [WIN_W-1:0] mod_rem;

    cgi_mod u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_time   (i_time_ms),
        .i_window (r_window),
        .o_valid  (mod_vld),
        .o_rem    (mod_rem)
    );

    // ramp position k and bypass flag
    logic [Q_W-1:0]   q;
    logic [WIN_W-1:0] h;
    logic [WIN_W:0]   hq;
    logic [WIN_W-1:0] s;
    logic [WIN_W-1:0] n_k;
    logic             n_byp;
    logic             r_k_vld;
    logic [WIN_W-1:0] r_k;
    logic             r_k_byp;

    always_comb begin
        q     = r_window[WIN_W-1:2];
        h     = {1'b0, r_window[WIN_W-1:1]};
        hq    = {1'b0, h} + {3'b0, q};
        s     = mod_rem - {2'b0, q};
        n_k   = (s < {2'b0, q}) ? s : WIN_W'(h - s);
        n_byp = (q == '0) || (mod_rem < {2'b0, q}) || ({1'b0, mod_rem} > hq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else begin
            r_k_vld <= mod_vld;
        end
        r_k     <= n_k;
        r_k_byp <= n_byp;
    end

    // per-channel product |peak - base| * k
    logic              r_p_vld;
    logic              r_p_byp;
    logic [NUM_CH-1:0] r_p_neg;
    logic [PROD_W-1:0] r_p_prod [NUM_CH];

    genvar gc;
    generate
        for (gc = 0; gc < NUM_CH; gc++) begin : g_prod
            logic [CH_W-1:0] b_ch;
            logic [CH_W-1:0] p_ch;
            logic [CH_W-1:0] mag;
            logic            neg;

            assign b_ch = r_base[gc*CH_W +: CH_W];
            assign p_ch = r_peak[gc*CH_W +: CH_W];
            assign neg  = p_ch < b_ch;
            assign mag  = neg ? CH_W'(b_ch - p_ch) : CH_W'(p_ch - b_ch);

            always_ff @(posedge i_clk) begin
                r_p_neg[gc]  <= neg;
                r_p_prod[gc] <= PROD_W'(mag) * PROD_W'(r_k);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_k_vld;
        end
        r_p_byp <= r_k_byp;
    end

    // blend divide by q, one quotient bit a stage, all channels side by side
    logic [PROD_W-1:0] r_d_vld;
    logic [PROD_W-1:0] r_d_byp;
    logic [NUM_CH-1:0] r_d_neg [PROD_W];
    logic [Q_W-1:0]    r_d_rem [PROD_W][NUM_CH];
    logic [PROD_W-1:0] r_d_num [PROD_W][NUM_CH];

    genvar gs, gd;
    generate
        for (gs = 0; gs < PROD_W; gs++) begin : g_div
            logic in_vld;
            logic in_byp;
            logic [NUM_CH-1:0] in_neg;

            if (gs == 0) begin : g_first
                assign in_vld = r_p_vld;
                assign in_byp = r_p_byp;
                assign in_neg = r_p_neg;
            end else begin : g_next
                assign in_vld = r_d_vld[gs-1];
                assign in_byp = r_d_byp[gs-1];
                assign in_neg = r_d_neg[gs-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d_vld[gs] <= 1'b0;
                end else begin
                    r_d_vld[gs] <= in_vld;
                end
                r_d_byp[gs] <= in_byp;
                r_d_neg[gs] <= in_neg;
            end

            for (gd = 0; gd < NUM_CH; gd++) begin : g_ch
                logic [Q_W-1:0]    in_rem;
                logic [PROD_W-1:0] in_num;
                logic [Q_W:0]      trial;
                logic              fits;

                if (gs == 0) begin : g_first
                    assign in_rem = '0;
                    assign in_num = r_p_prod[gd];
                end else begin : g_next
                    assign in_rem = r_d_rem[gs-1][gd];
                    assign in_num = r_d_num[gs-1][gd];
                end

                assign trial = {in_rem, in_num[PROD_W-1]};
                assign fits  = trial >= {1'b0, q};

                always_ff @(posedge i_clk) begin
                    r_d_rem[gs][gd] <= fits ? Q_W'(trial - {1'b0, q}) : trial[Q_W-1:0];
                    r_d_num[gs][gd] <= {in_num[PROD_W-2:0], fits};
                end
            end
        end
    endgenerate

    // apply signed offset, saturate, pack; on bypass the base colour is kept
    logic [COLOR_W-1:0] n_color;

    always_comb begin
        logic [QUO_W-1:0]   quo;
        logic signed [11:0] v;
        n_color = r_base;
        for (int c = 0; c < NUM_CH; c++) begin
            quo = r_d_num[PROD_W-1][c][QUO_W-1:0];
            if (r_d_neg[PROD_W-1][c]) begin
                v = $signed({4'b0, r_base[c*CH_W +: CH_W]}) - $signed({2'b0, quo});
            end else begin
                v = $signed({4'b0, r_base[c*CH_W +: CH_W]}) + $signed({2'b0, quo});
            end
            if (!r_d_byp[PROD_W-1]) begin
                if (v < 0) begin
                    n_color[c*CH_W +: CH_W] = '0;
                end else if (v > 12'sd255) begin
                    n_color[c*CH_W +: CH_W] = '1;
                end else begin
                    n_color[c*CH_W +: CH_W] = v[CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_d_vld[PROD_W-1];
        end
        o_color_out <= n_color;
    end

endmodule

`default_nettype wire

[hw/rtl/cgi_checker.sv]
// ----------------------------------------------------------------------------
// cgi_checker
// Port-level checks of the colour glow interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cgi_checker
    import cgi_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_cfg_ready
);

    // a command is always taken
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // every result stems from an earlier command on start
    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without command");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config port not ready");

endmodule

bind color_glow_interpolator cgi_checker u_cgi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

[verif/color_glow_interpolator_test.sv]
// ----------------------------------------------------------------------------
// color_glow_interpolator_test
// Self-checking bench for the colour glow interpolator. Time stamps are
// pushed through the command channel in random bursts, each expected colour
// is computed by a local triangular-crossfade predictor and compared with
// the result stream in order. Window and colours are rewritten between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module color_glow_interpolator_test;
    import cgi_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [TIME_W-1:0]  i_time_ms = '0;
    logic               o_valid;
    logic [COLOR_W-1:0] o_color_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = REG_WINDOW;
    logic [COLOR_W-1:0] i_cfg_data = '0;

    color_glow_interpolator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_time_ms   (i_time_ms),
        .o_valid     (o_valid),
        .o_color_out (o_color_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [WIN_W-1:0]   win_reg  = WINDOW_RST;
    logic [COLOR_W-1:0] base_reg = BASE_RST;
    logic [COLOR_W-1:0] peak_reg = PEAK_RST;

    logic [TIME_W-1:0]  pending_times[$];
    logic [COLOR_W-1:0] expected_colors[$];
    int unsigned        mismatch_count = 0;
    int unsigned        idle_cycles = 0;

    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] b,
                                              input logic [CH_W-1:0] p,
                                              input int k, input int q);
        int v;
        v = int'(b) + ((int'(p) - int'(b)) * k) / q;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[CH_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] glow_color(input logic [TIME_W-1:0] t);
        longint unsigned w, q, h, p, s, k;
        logic [COLOR_W-1:0] c;
        w = win_reg;
        q = w / 4;
        h = w / 2;
        c = base_reg;
        if (q != 0) begin
            p = t % w;
            if (!(p < q || p > h + q)) begin
                s = p - q;
                k = (s < q) ? s : h - s;
                c = {blend(base_reg[23:16], peak_reg[23:16], int'(k), int'(q)),
                     blend(base_reg[15:8],  peak_reg[15:8],  int'(k), int'(q)),
                     blend(base_reg[7:0],   peak_reg[7:0],   int'(k), int'(q))};
            end
        end
        return c;
    endfunction

    task automatic report(input string what);
        $display("MISMATCH: %s", what);
        mismatch_count++;
    endtask

    // driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            // transfer happened at the last rising edge; predict it
            expected_colors.push_back(glow_color(i_time_ms));
            void'(pending_times.pop_front());
        end
        if (!i_rst_n || pending_times.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else begin
            start     <= 1'b1;
            i_time_ms <= pending_times[0];
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 30);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_colors.size() == 0) begin
                report($sformatf("unexpected colour %06h", o_color_out));
            end else begin
                if (o_color_out !== expected_colors[0])
                    report($sformatf("colour_out got %06h want %06h",
                                     o_color_out, expected_colors[0]));
                void'(expected_colors.pop_front());
            end
        end
        if (o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [COLOR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW: win_reg  = val[WIN_W-1:0];
            REG_BASE:   base_reg = val;
            REG_PEAK:   peak_reg = val;
            default: ;
        endcase
    endtask

    // wait for the pipeline to empty
    task automatic drain();
        while (pending_times.size() != 0 || start || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic random_times(input int n, input bit near_window);
        logic [TIME_W-1:0] t;
        repeat (n) begin
            if (near_window && win_reg != 0)
                t = $urandom_range(0, 3 * win_reg);
            else
                t = $urandom;
            pending_times.push_back(t);
        end
    endtask

    initial begin
        logic [WIN_W-1:0] w;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset configuration, field extremes and ramp corners
        pending_times.push_back(32'd0);
        pending_times.push_back(32'hFFFF_FFFF);
        pending_times.push_back(32'h5555_5555);
        pending_times.push_back(32'hAAAA_AAAA);
        pending_times.push_back(32'd499);
        pending_times.push_back(32'd500);
        pending_times.push_back(32'd999);
        pending_times.push_back(32'd1000);
        pending_times.push_back(32'd1500);
        pending_times.push_back(32'd1501);
        drain();

        // overshoot near the peak: window mod 4 of 3, falling and rising colours
        write_reg(REG_WINDOW, 24'd7);
        write_reg(REG_BASE, 24'hFF00FF);
        write_reg(REG_PEAK, 24'h00FF80);
        for (int i = 0; i < 8; i++) pending_times.push_back(TIME_W'(i));
        // index beyond the list is ignored
        drain();
        write_reg(REG_NONE, 24'h123456);
        pending_times.push_back(32'd4);
        drain();

        // short window and zero window give the base colour
        write_reg(REG_WINDOW, 24'd3);
        pending_times.push_back(32'hFFFF_FFFF);
        pending_times.push_back(32'd2);
        drain();
        write_reg(REG_WINDOW, 24'd0);
        pending_times.push_back(32'd123);
        drain();

        // largest window
        write_reg(REG_WINDOW, 24'hFFFF);
        write_reg(REG_BASE, 24'h000000);
        write_reg(REG_PEAK, 24'hFFFFFF);
        pending_times.push_back(32'd32767);
        pending_times.push_back(32'd49151);
        pending_times.push_back(32'hFFFF_FFFF);
        drain();

        // random phases over many settings
        for (int ph = 0; ph < 18; ph++) begin
            case (ph % 4)
                0: w = WIN_W'($urandom_range(4, 12));
                1: w = WIN_W'(16'hFFFC + $urandom_range(0, 3));
                2: w = WIN_W'($urandom_range(0, 3));
                default: w = WIN_W'($urandom);
            endcase
            write_reg(REG_WINDOW, COLOR_W'(w));
            write_reg(REG_BASE, (ph % 5 == 0) ? 24'hFFFFFF : 24'($urandom));
            write_reg(REG_PEAK, (ph % 5 == 1) ? 24'h000000 : 24'($urandom));
            random_times(50, ph % 3 != 0);
            drain();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/cgi_pkg.sv
hw/rtl/cgi_mod.sv
hw/rtl/color_glow_interpolator.sv
hw/rtl/cgi_checker.sv
verif/color_glow_interpolator_test.sv
